### hw/rtl/sil_pkg.sv
// Package for the sorted insertion list: request and response words,
// request codes, sequencer states and the per-cell control bundle.
// No dependencies.
package sil_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 7;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_FIND   = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]                action;
      logic signed [VALUE_W-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic               found;
      logic               accepted;
      logic [COUNT_W-1:0] count;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_APPLY
   } state_type;

   typedef struct packed {
      logic                      compare;
      logic                      write;
      logic signed [VALUE_W-1:0] value;
   } cell_ctrl_type;

endpackage

### hw/rtl/sorted_insert_list_unit.sv
// Top level of the sorted insertion list: request sequencer, fill count and
// the chain of compare cells. Depends on sil_pkg and sil_cell.
//
// Usage:
//   A request word (action, value) is taken at a rising edge where start is
//   high and busy is low. Actions: insert, find, clear; other codes leave the
//   list as it is. Each request yields one response word, shown on rsp_word
//   for exactly one cycle with rsp_strobe high; the receiver cannot stall.
//   The request is registered and passes through the compare state, then the
//   apply state, where the response is shown.
//   In the compare state every cell compares its entry with the value; in
//   the apply state the insert shifts larger entries one slot up in a single
//   step and the per-cell match flags are ORed into the found bit.
//   A new request can be taken while a response is shown: busy is high only
//   in the compare state.
//   count reports the low 7 bits of the entry count after the request.
//   Reset empties the list at once (fill count to zero); entry contents are
//   not cleared and are never read before being written.
module sorted_insert_list_unit #(
   parameter int CAPACITY = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  sil_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output sil_pkg::rsp_word_type rsp_word
);

   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam logic [FILL_W-1:0] FULL = FILL_W'(CAPACITY);

   sil_pkg::state_type     state_ff, state_in;
   sil_pkg::req_word_type  req_ff, req_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   sil_pkg::cell_ctrl_type ctrl;
   logic                   take;
   logic                   room;

   logic signed [sil_pkg::VALUE_W-1:0] entry_vec [CAPACITY];
   logic [CAPACITY-1:0]                gt_vec;
   logic [CAPACITY-1:0]                eq_vec;

   assign busy = state_ff == sil_pkg::ST_COMPARE;
   assign take = start && !busy;
   assign room = fill_ff < FULL;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      fill_in      = fill_ff;
      ctrl.compare = 1'b0;
      ctrl.write   = 1'b0;
      ctrl.value   = req_ff.value;
      rsp_strobe   = 1'b0;
      rsp_word     = '0;
      if (take) begin
         req_in = req_word;
      end
      unique case (state_ff)
         sil_pkg::ST_IDLE: begin
            if (take) begin
               state_in = sil_pkg::ST_COMPARE;
            end
         end
         sil_pkg::ST_COMPARE: begin
            ctrl.compare = 1'b1;
            state_in     = sil_pkg::ST_APPLY;
         end
         sil_pkg::ST_APPLY: begin
            rsp_strobe = 1'b1;
            unique case (req_ff.action)
               sil_pkg::ACT_INSERT: begin
                  if (room) begin
                     ctrl.write = 1'b1;
                     fill_in    = fill_ff + FILL_W'(1);
                     rsp_word.accepted = 1'b1;
                  end
               end
               sil_pkg::ACT_FIND: begin
                  rsp_word.found = |eq_vec;
               end
               sil_pkg::ACT_CLEAR: begin
                  fill_in = '0;
               end
               default: begin
               end
            endcase
            rsp_word.count = sil_pkg::COUNT_W'(fill_in);
            state_in = take ? sil_pkg::ST_COMPARE : sil_pkg::ST_IDLE;
         end
         default: begin
            state_in = sil_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sil_pkg::ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
      req_ff <= req_in;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [sil_pkg::VALUE_W-1:0] left_entry;
      logic                               left_gt;
      if (i == 0) begin : g_head
         assign left_entry = '0;
         assign left_gt    = 1'b0;
      end else begin : g_link
         assign left_entry = entry_vec[i-1];
         assign left_gt    = gt_vec[i-1];
      end
      sil_cell #(
         .INDEX  (i),
         .FILL_W (FILL_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .fill       (fill_ff),
         .left_entry (left_entry),
         .left_gt    (left_gt),
         .entry      (entry_vec[i]),
         .gt         (gt_vec[i]),
         .eq         (eq_vec[i])
      );
   end

endmodule

### hw/rtl/sil_cell.sv
// One slot of the sorted insertion list: holds an entry, compares it with
// the request value and takes its left neighbor's entry on a shifting insert.
// Depends on sil_pkg.
module sil_cell #(
   parameter int INDEX  = 0,
   parameter int FILL_W = 7
) (
   input  logic                               clock,
   input  sil_pkg::cell_ctrl_type             ctrl,
   input  logic [FILL_W-1:0]                  fill,
   input  logic signed [sil_pkg::VALUE_W-1:0] left_entry,
   input  logic                               left_gt,
   output logic signed [sil_pkg::VALUE_W-1:0] entry,
   output logic                               gt,
   output logic                               eq
);

   localparam logic [FILL_W-1:0] SLOT = FILL_W'(INDEX);

   logic signed [sil_pkg::VALUE_W-1:0] entry_ff, entry_in;
   logic                               gt_ff, gt_in;
   logic                               eq_ff, eq_in;
   logic                               occupied;
   logic                               tail;

   assign occupied = SLOT < fill;
   assign tail     = SLOT == fill;

   always_comb begin
      entry_in = entry_ff;
      gt_in    = gt_ff;
      eq_in    = eq_ff;
      if (ctrl.compare) begin
         gt_in = occupied && (entry_ff > ctrl.value);
         eq_in = occupied && (entry_ff == ctrl.value);
      end
      if (ctrl.write && (gt_ff || tail)) begin
         entry_in = left_gt ? left_entry : ctrl.value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      gt_ff    <= gt_in;
      eq_ff    <= eq_in;
   end

   assign entry = entry_ff;
   assign gt    = gt_ff;
   assign eq    = eq_ff;

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_insert_list_unit: drives insert, find, clear
// and unused-code words with random gaps and checks each response against a sorted
// queue model. Depends on sil_pkg and the sorted_insert_list_unit RTL.
module tb_top;

   localparam int CAPACITY = 64;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   sil_pkg::req_word_type req_word;
   logic                  rsp_strobe;
   sil_pkg::rsp_word_type rsp_word;

   logic signed [sil_pkg::VALUE_W-1:0] list_model[$];
   sil_pkg::rsp_word_type              expected_rsp_q[$];
   sil_pkg::rsp_word_type              expected_head;

   int error_count;
   int words_sent;
   int responses_checked;
   int inserts_dropped;
   int finds_hit;

   sorted_insert_list_unit #(
      .CAPACITY(CAPACITY)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_strobe(rsp_strobe),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Timeout at %0t", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic sil_pkg::rsp_word_type predict_list_response(sil_pkg::req_word_type w);
      sil_pkg::rsp_word_type              r;
      logic signed [sil_pkg::VALUE_W-1:0] v;
      int                                 pos;
      r = '0;
      v = w.value;
      case (w.action)
         sil_pkg::ACT_INSERT: begin
            if (list_model.size() < CAPACITY) begin
               pos = 0;
               while (pos < list_model.size() && list_model[pos] <= v) pos++;
               list_model.insert(pos, v);
               r.accepted = 1'b1;
            end else begin
               inserts_dropped++;
            end
         end
         sil_pkg::ACT_FIND: begin
            foreach (list_model[k]) begin
               if (list_model[k] == v) r.found = 1'b1;
            end
            if (r.found) finds_hit++;
         end
         sil_pkg::ACT_CLEAR: list_model.delete();
         default: ;
      endcase
      r.count = sil_pkg::COUNT_W'(list_model.size());
      return r;
   endfunction

   task automatic check_field(input string name, input int expv, input int actv);
      if (expv != actv) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expv, actv);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual %p", $time, rsp_word);
            error_count++;
         end else begin
            expected_head = expected_rsp_q.pop_front();
            check_field("found", int'(expected_head.found), int'(rsp_word.found));
            check_field("accepted", int'(expected_head.accepted), int'(rsp_word.accepted));
            check_field("count", int'(expected_head.count), int'(rsp_word.count));
            responses_checked++;
         end
      end
   end

   task automatic send_request(input logic [1:0] action,
                               input logic signed [sil_pkg::VALUE_W-1:0] value);
      sil_pkg::req_word_type w;
      w.action = action;
      w.value  = value;
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      expected_rsp_q.push_back(predict_list_response(w));
      words_sent++;
   endtask

   task automatic maybe_idle(input int idle_pct);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [sil_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh8000_0000 + $urandom_range(0, 3);
         1:       return 32'sh7fff_ffff - $urandom_range(0, 3);
         2, 3, 4: return $signed($urandom_range(0, 16)) - 8;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed_corners();
      send_request(sil_pkg::ACT_FIND, 0);
      send_request(sil_pkg::ACT_INSERT, 32'sh7fff_ffff);
      send_request(sil_pkg::ACT_INSERT, 32'sh8000_0000);
      send_request(sil_pkg::ACT_FIND, 32'sh8000_0000);
      send_request(sil_pkg::ACT_FIND, 32'sh7fff_ffff);
      send_request(sil_pkg::ACT_CLEAR, 32'sh5555_aaaa);
      send_request(sil_pkg::ACT_FIND, 32'sh7fff_ffff);
      send_request(sil_pkg::ACT_INSERT, 5);
      send_request(sil_pkg::ACT_INSERT, -5);
      send_request(sil_pkg::ACT_FIND, -5);
      send_request(sil_pkg::ACT_INSERT, 5);
      send_request(sil_pkg::ACT_INSERT, 0);
      send_request(sil_pkg::ACT_INSERT, -1);
      send_request(sil_pkg::ACT_FIND, 5);
      send_request(sil_pkg::ACT_FIND, 1);
      send_request(ACT_UNUSED, 0);
      send_request(ACT_UNUSED, -1);
      send_request(sil_pkg::ACT_FIND, -1);
      send_request(sil_pkg::ACT_INSERT, 32'sh8000_0000);
      send_request(sil_pkg::ACT_INSERT, 32'sh7fff_ffff);
      send_request(sil_pkg::ACT_FIND, 32'sh8000_0000);
      send_request(sil_pkg::ACT_CLEAR, 0);
      send_request(sil_pkg::ACT_CLEAR, 0);
      send_request(sil_pkg::ACT_FIND, 0);
   endtask

   task automatic test_fill_to_capacity();
      send_request(sil_pkg::ACT_CLEAR, 0);
      repeat (CAPACITY + 6) begin
         send_request(sil_pkg::ACT_INSERT, $signed($urandom_range(0, 40)) - 20);
         maybe_idle(15);
      end
      send_request(sil_pkg::ACT_INSERT, 32'sh8000_0000);
      send_request(sil_pkg::ACT_INSERT, 32'sh7fff_ffff);
      repeat (8) send_request(sil_pkg::ACT_FIND, $signed($urandom_range(0, 50)) - 25);
      send_request(ACT_UNUSED, 1);
      send_request(sil_pkg::ACT_CLEAR, 0);
      send_request(sil_pkg::ACT_INSERT, 7);
   endtask

   task automatic test_random_traffic(input int n, input int clear_pct, input int idle_pct);
      int pick;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < clear_pct) begin
            send_request(sil_pkg::ACT_CLEAR, $urandom);
         end else if (pick < clear_pct + 3) begin
            send_request(ACT_UNUSED, $urandom);
         end else if (pick < clear_pct + 53) begin
            send_request(sil_pkg::ACT_INSERT, pick_value());
         end else if (list_model.size() != 0 && $urandom_range(0, 1)) begin
            send_request(sil_pkg::ACT_FIND,
                         list_model[$urandom_range(0, list_model.size() - 1)]);
         end else begin
            send_request(sil_pkg::ACT_FIND, pick_value());
         end
         maybe_idle(idle_pct);
      end
   endtask

   task automatic test_drain_pause();
      test_random_traffic(10, 2, 20);
      wait_for_drain();
      send_request(sil_pkg::ACT_FIND, pick_value());
      test_random_traffic(10, 2, 20);
   endtask

   initial begin
      error_count       = 0;
      words_sent        = 0;
      responses_checked = 0;
      inserts_dropped   = 0;
      finds_hit         = 0;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_word <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_corners();
      test_fill_to_capacity();
      test_random_traffic(400, 1, 25);
      test_random_traffic(400, 6, 0);
      test_drain_pause();
      test_random_traffic(300, 2, 40);
      test_random_traffic(200, 3, 0);

      wait_for_drain();
      repeat (4) @(posedge clock);
      $display("Sent %0d words, checked %0d responses", words_sent, responses_checked);
      $display("Full-list drops: %0d, find hits: %0d", inserts_dropped, finds_hit);
      if (error_count == 0 && expected_rsp_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
